/* rtl/periodic_task_tick_scheduler_unit_macros.svh */
// Assertion macros for the periodic task tick scheduler.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_UNIT_MACROS_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PTTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define PTTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ptts_pkg.sv */
// Shared types and constants for the periodic task tick scheduler.
// No dependencies; imported by every module of the block.
package ptts_pkg;

    localparam int NUM_TASKS = 4;
    localparam int SLOTS     = 4;
    localparam int REG_W     = 15;
    localparam int STEP_W    = 2;
    localparam int ACT_W     = 3;
    localparam int CNT_W     = 8;
    localparam int IDX_W     = 3;

    localparam logic [ACT_W-1:0] TASK_LIMIT = ACT_W'(NUM_TASKS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SLOTS - 1);

    // Request codes
    typedef enum logic [1:0] {
        REQ_START    = 2'd0,
        REQ_TICK     = 2'd1,
        REQ_DISPATCH = 2'd2
    } t_req;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RUN   = 2'd1,
        ST_FLUSH = 2'd2
    } t_state;

    // Per-task state carried around the ring
    typedef struct packed {
        logic             rdy;
        logic [REG_W-1:0] cd;
    } t_slot;

    // Control handed to the head update unit
    typedef struct packed {
        logic [1:0]        req;
        logic [STEP_W-1:0] step;
        logic [ACT_W-1:0]  active;
    } t_upd_ctrl;

endpackage

/* rtl/periodic_task_tick_scheduler_unit.sv */
// Periodic task tick scheduler: a ring of four per-task countdown cells.
// Each accepted transaction rotates the ring once, one slot per cycle through
// the head update unit, then through the flush state back to idle for acceptance;
// a dispatch stalls the ring while the result register is full and not taken.
// Dispatch results come out in task order, the final one with o_last set.
// Configuration writes are registered.
// Depends on ptts_pkg, ptts_cell, ptts_upd and the assertion macro header.
`include "periodic_task_tick_scheduler_unit_macros.svh"

module periodic_task_tick_scheduler_unit import ptts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [REG_W-1:0]  i_cfg_data,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_req_type,
    input  logic [CNT_W-1:0]  i_active_count,
    // dispatch result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STEP_W-1:0] o_task_index,
    output logic              o_last
);

    t_state             r_state, n_state;
    logic [1:0]         r_req;
    logic [STEP_W-1:0]  r_step;
    logic [ACT_W-1:0]   r_active;
    logic [REG_W-1:0]   r_period [SLOTS];
    logic [REG_W-1:0]   r_offset [SLOTS];
    logic               r_pend_valid;
    logic [STEP_W-1:0]  r_pend_idx;
    logic               r_out_valid;
    logic [STEP_W-1:0]  r_out_idx;
    logic               r_out_last;

    t_slot              cell_q [SLOTS];
    t_slot              head_nxt;
    t_upd_ctrl          upd_ctrl;
    logic               emit;
    logic               out_free;
    logic               in_acc;
    logic               advance;
    logic               push_run;
    logic               push_flush;
    logic [ACT_W-1:0]   clamp_cnt;

    // Configuration registers, low half periods, high half offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_period[k] <= '0;
                r_offset[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx[IDX_W-1]) begin
                r_offset[i_cfg_idx[STEP_W-1:0]] <= i_cfg_data;
            end else begin
                r_period[i_cfg_idx[STEP_W-1:0]] <= i_cfg_data;
            end
        end
    end

    // Ring of cells; the head feeds the update unit, its result enters the tail
    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            t_slot cell_d;
            if (g == SLOTS - 1) begin : g_tail
                assign cell_d = head_nxt;
            end else begin : g_mid
                assign cell_d = cell_q[g+1];
            end
            ptts_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (advance),
                .i_slot  (cell_d),
                .o_slot  (cell_q[g])
            );
        end
    endgenerate

    assign upd_ctrl = '{req: r_req, step: r_step, active: r_active};

    ptts_upd u_upd (
        .i_ctrl   (upd_ctrl),
        .i_slot   (cell_q[0]),
        .i_period (r_period[r_step]),
        .i_offset (r_offset[r_step]),
        .o_slot   (head_nxt),
        .o_emit   (emit)
    );

    assign clamp_cnt = (i_active_count < CNT_W'(NUM_TASKS)) ?
                       i_active_count[ACT_W-1:0] : TASK_LIMIT;
    assign out_free  = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (advance && r_step == LAST_STEP) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!r_pend_valid || out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_in_ready = 1'b0;
        advance    = 1'b0;
        push_run   = 1'b0;
        push_flush = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_RUN: begin
                advance  = !emit || !r_pend_valid || out_free;
                push_run = emit && r_pend_valid && out_free;
            end
            ST_FLUSH: begin
                push_flush = r_pend_valid && out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign in_acc = i_in_valid && o_in_ready;

    // Sequencer, request and pending-result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_req        <= '0;
            r_step       <= '0;
            r_active     <= '0;
            r_pend_valid <= 1'b0;
            r_pend_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_req  <= i_req_type;
                r_step <= '0;
                if (t_req'(i_req_type) == REQ_START) r_active <= clamp_cnt;
            end else if (advance) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (advance && emit) begin
                r_pend_valid <= 1'b1;
                r_pend_idx   <= r_step;
            end else if (push_flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push_run || push_flush) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_run || push_flush) begin
            r_out_idx  <= r_pend_idx;
            r_out_last <= push_flush;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_task_index = r_out_idx;
    assign o_last       = r_out_last;

    // Checks
    `PTTS_ASSERT_NOW(a_idle_no_pend, r_state == ST_IDLE, !r_pend_valid, "pending result left in idle")
    `PTTS_ASSERT_NEXT(a_acc_starts, in_acc, (r_state == ST_RUN) && (r_step == '0), "accepted transaction did not start at step zero")
    `PTTS_ASSERT_NEXT(a_stall_holds, (r_state == ST_RUN) && emit && r_pend_valid && !out_free, $stable(r_step) && (r_state == ST_RUN), "ring advanced over a blocked result")
    `PTTS_ASSERT_NOW(a_push_free, push_run || push_flush, out_free, "result pushed into a full register")

endmodule

/* rtl/ptts_cell.sv */
// One ring cell: holds the countdown and ready flag of one task slot.
// Depends on ptts_pkg.
module ptts_cell import ptts_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_slot i_slot,
    output t_slot o_slot
);

    t_slot r_slot;

    // Take the neighbor's contents on every ring advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_shift) begin
            r_slot <= i_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

/* rtl/ptts_upd.sv */
// Head update unit: applies start, tick or dispatch to the slot at the ring head.
// Depends on ptts_pkg.
module ptts_upd import ptts_pkg::*; (
    input  t_upd_ctrl        i_ctrl,
    input  t_slot            i_slot,
    input  logic [REG_W-1:0] i_period,
    input  logic [REG_W-1:0] i_offset,
    output t_slot            o_slot,
    output logic             o_emit
);

    logic hit;

    assign hit = {1'b0, i_ctrl.step} < i_ctrl.active;

    always_comb begin
        o_slot = i_slot;
        o_emit = 1'b0;
        unique case (t_req'(i_ctrl.req))
            REQ_START: begin
                // flags clear on every slot, countdown loads only on active ones
                o_slot.rdy = 1'b0;
                if (hit) begin
                    o_slot.cd = (i_offset != '0) ? i_offset : i_period;
                end
            end
            REQ_TICK: begin
                if (hit) begin
                    if (i_slot.cd <= REG_W'(1)) begin
                        o_slot.rdy = 1'b1;
                        o_slot.cd  = i_period;
                    end else begin
                        o_slot.cd = i_slot.cd - REG_W'(1);
                    end
                end
            end
            REQ_DISPATCH: begin
                if (hit && i_slot.rdy) begin
                    o_slot.rdy = 1'b0;
                    o_emit     = 1'b1;
                end
            end
            default: begin
                // unknown request: no change
            end
        endcase
    end

endmodule
